// ----- src/hlcs_pkg.sv -----
// shared constants for the hirschberg lcs engine
`timescale 1ns / 1ps
`default_nettype none
package hlcs_pkg;
  localparam int DEF_MAX_LEN     = 1024;
  localparam int DEF_STACK_DEPTH = 24;

  localparam int KIND_W   = 3;
  localparam int SYM_W    = 8;
  localparam int IDX_W    = 10;
  localparam int LEN_W    = 11;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_APPEND_X = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND_Y = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RUN      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd2;
endpackage
`default_nettype wire

// ----- src/hirschberg_lcs_top.sv -----
// hirschberg longest common subsequence engine, top level
//
// channel   ports                                        handshake
// -------   -------------------------------------------  -------------------------------
// input     in_kind, in_symbol, in_read_index            start high and busy low at edge
// result    out_status, out_subseq_length,               out_valid high for one cycle
//           out_read_symbol
//
// appends, clear and undefined kinds are answered straight from idle, a read goes through S_RD first
// in a run one score cell unit does every cell of every forward and reverse row,
// each cell in S_CA (row memory read) and then S_CB (update)
// reset only clears counts, stack pointer, result strobe and sequencer; stores need no clearing pass
// the receiver cannot stall; each transaction gives exactly one result strobe
`timescale 1ns / 1ps
`default_nettype none
module hirschberg_lcs_top #(
  parameter int MAX_LEN     = hlcs_pkg::DEF_MAX_LEN,
  parameter int STACK_DEPTH = hlcs_pkg::DEF_STACK_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [hlcs_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [hlcs_pkg::SYM_W-1:0]    in_symbol,
  input  wire logic [hlcs_pkg::IDX_W-1:0]    in_read_index,
  output logic                               out_valid,
  output logic [hlcs_pkg::STATUS_W-1:0]      out_status,
  output logic [hlcs_pkg::LEN_W-1:0]         out_subseq_length,
  output logic [hlcs_pkg::SYM_W-1:0]         out_read_symbol
);
  // address width of the symbol stores, count width that also holds MAX_LEN
  localparam int AW  = $clog2(MAX_LEN);
  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SW  = hlcs_pkg::SYM_W;

  // one subproblem: x start, x length, y start, y length
  typedef struct packed {
    logic [CW-1:0] xs;
    logic [CW-1:0] xl;
    logic [CW-1:0] ys;
    logic [CW-1:0] yl;
  } task_t;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RD    = 12'b000000000010,
    S_POP   = 12'b000000000100,
    S_SG_A  = 12'b000000001000,  // single x symbol: issue reads
    S_SG_B  = 12'b000000010000,  // single x symbol: compare
    S_INIT  = 12'b000000100000,  // zero a score row
    S_ROW_I = 12'b000001000000,  // next x symbol of a row
    S_CA    = 12'b000010000000,  // cell: issue y and row reads
    S_CB    = 12'b000100000000,  // cell: update and write back
    S_SA    = 12'b001000000000,  // split scan: issue row reads
    S_SB    = 12'b010000000000,  // split scan: compare sum
    S_PUSH  = 12'b100000000000
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   x_count_r, y_count_r, rc_r;
  logic [CW-1:0]   t_xs_r, t_xl_r, t_ys_r, t_yl_r;
  logic            bwd_r;
  logic [CW-1:0]   i_r, j_r, diag_r, left_r, k_r;
  logic [CW:0]     best_r;
  logic            found_r;
  logic [SW-1:0]   a_r;
  logic [SPW-1:0]  sp_r;
  task_t           stack_r [STACK_DEPTH];
  logic            rd_ok_r;
  logic            out_valid_r;
  logic [hlcs_pkg::STATUS_W-1:0] out_status_r;
  logic [SW-1:0]   out_sym_r;

  // memories
  logic [SW-1:0] x_store [MAX_LEN];
  logic [SW-1:0] y_store [MAX_LEN];
  logic [SW-1:0] r_store [MAX_LEN];
  logic [CW-1:0] fwd_row [MAX_LEN+1];
  logic [CW-1:0] rev_row [MAX_LEN+1];

  logic [SW-1:0] x_rdata, y_rdata, r_rdata;
  logic [CW-1:0] fwd_rdata, rev_rdata;
  logic [CW-1:0] x_raddr, y_raddr, fwd_raddr, rev_raddr, row_waddr, row_wdata;
  logic          row_we, rs_we;

  logic          accept;
  logic [CW-1:0] half, r_xs, r_xl, above, cell_new;
  logic [CW:0]   sum;
  logic          sg_match, sg_found, x_has_room, y_has_room, rc_room;
  task_t         top_task, right_task, left_task;

  assign busy              = (state_r != S_IDLE);
  assign accept            = start && !busy;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_subseq_length = hlcs_pkg::LEN_W'(rc_r);
  assign out_read_symbol   = out_sym_r;

  assign x_has_room = (x_count_r < CW'(MAX_LEN));
  assign y_has_room = (y_count_r < CW'(MAX_LEN));
  assign rc_room    = (rc_r < CW'(MAX_LEN));

  // current subproblem halves
  assign half = t_xl_r >> 1;
  assign r_xs = bwd_r ? (t_xs_r + half) : t_xs_r;
  assign r_xl = bwd_r ? (t_xl_r - half) : half;

  // shared score cell
  assign above    = bwd_r ? rev_rdata : fwd_rdata;
  assign cell_new = (a_r == y_rdata) ? (diag_r + 1'b1) :
                    ((left_r > above) ? left_r : above);
  assign sum      = {1'b0, fwd_rdata} + {1'b0, rev_rdata};

  assign sg_match = (x_rdata == y_rdata);
  assign sg_found = found_r || sg_match;

  assign top_task   = stack_r[SIW'(sp_r - 1'b1)];
  assign right_task = '{xs: t_xs_r + half, xl: t_xl_r - half,
                        ys: t_ys_r + k_r, yl: t_yl_r - k_r};
  assign left_task  = '{xs: t_xs_r, xl: half, ys: t_ys_r, yl: k_r};

  // memory addressing by sequencer step
  always_comb begin
    x_raddr   = t_xs_r;
    y_raddr   = t_ys_r + j_r;
    fwd_raddr = j_r;
    rev_raddr = j_r;
    row_we    = 1'b0;
    row_waddr = j_r;
    row_wdata = '0;
    rs_we     = 1'b0;
    unique case (state_r)
      S_ROW_I: x_raddr = bwd_r ? (r_xs + r_xl - i_r) : (r_xs + i_r - 1'b1);
      S_CA:    y_raddr = bwd_r ? (t_ys_r + t_yl_r - j_r) : (t_ys_r + j_r - 1'b1);
      S_SA:    rev_raddr = t_yl_r - j_r;
      S_INIT:  row_we = 1'b1;
      S_CB: begin
        row_we    = 1'b1;
        row_wdata = cell_new;
      end
      S_SG_B:  rs_we = (j_r == t_yl_r - 1'b1) && sg_found && rc_room;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && in_kind == hlcs_pkg::KIND_APPEND_X && x_has_room) begin
      x_store[AW'(x_count_r)] <= in_symbol;
    end
    x_rdata <= x_store[AW'(x_raddr)];
  end

  always_ff @(posedge clk) begin
    if (accept && in_kind == hlcs_pkg::KIND_APPEND_Y && y_has_room) begin
      y_store[AW'(y_count_r)] <= in_symbol;
    end
    y_rdata <= y_store[AW'(y_raddr)];
  end

  always_ff @(posedge clk) begin
    if (rs_we) begin
      r_store[AW'(rc_r)] <= x_rdata;
    end
    r_rdata <= r_store[AW'(in_read_index)];
  end

  always_ff @(posedge clk) begin
    if (row_we && !bwd_r) begin
      fwd_row[row_waddr] <= row_wdata;
    end
    fwd_rdata <= fwd_row[fwd_raddr];
  end

  always_ff @(posedge clk) begin
    if (row_we && bwd_r) begin
      rev_row[row_waddr] <= row_wdata;
    end
    rev_rdata <= rev_row[rev_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_count_r   <= '0;
      y_count_r   <= '0;
      rc_r        <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_status_r <= hlcs_pkg::ST_OK;
            out_sym_r    <= '0;
            unique case (in_kind)
              hlcs_pkg::KIND_APPEND_X: begin
                out_valid_r <= 1'b1;
                if (x_has_room) x_count_r <= x_count_r + 1'b1;
                else out_status_r <= hlcs_pkg::ST_FULL;
              end
              hlcs_pkg::KIND_APPEND_Y: begin
                out_valid_r <= 1'b1;
                if (y_has_room) y_count_r <= y_count_r + 1'b1;
                else out_status_r <= hlcs_pkg::ST_FULL;
              end
              hlcs_pkg::KIND_RUN: begin
                rc_r       <= '0;
                stack_r[0] <= '{xs: '0, xl: x_count_r, ys: '0, yl: y_count_r};
                sp_r       <= SPW'(1);
                state_r    <= S_POP;
              end
              hlcs_pkg::KIND_READ: begin
                rd_ok_r <= (32'(in_read_index) < 32'(rc_r));
                state_r <= S_RD;
              end
              hlcs_pkg::KIND_CLEAR: begin
                out_valid_r <= 1'b1;
                x_count_r   <= '0;
                y_count_r   <= '0;
                rc_r        <= '0;
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_RD: begin
          out_valid_r  <= 1'b1;
          out_status_r <= rd_ok_r ? hlcs_pkg::ST_OK : hlcs_pkg::ST_BAD_IDX;
          out_sym_r    <= rd_ok_r ? r_rdata : '0;
          state_r      <= S_IDLE;
        end
        S_POP: begin
          if (sp_r == '0) begin
            // run finished
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            sp_r   <= sp_r - 1'b1;
            t_xs_r <= top_task.xs;
            t_xl_r <= top_task.xl;
            t_ys_r <= top_task.ys;
            t_yl_r <= top_task.yl;
            j_r     <= '0;
            found_r <= 1'b0;
            bwd_r   <= 1'b0;
            if (top_task.xl == '0 || top_task.yl == '0) begin
              state_r <= S_POP;
            end else if (top_task.xl == CW'(1)) begin
              state_r <= S_SG_A;
            end else begin
              state_r <= S_INIT;
            end
          end
        end
        S_SG_A: state_r <= S_SG_B;
        S_SG_B: begin
          found_r <= sg_found;
          if (j_r == t_yl_r - 1'b1) begin
            if (sg_found && rc_room) rc_r <= rc_r + 1'b1;
            state_r <= S_POP;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_SG_A;
          end
        end
        S_INIT: begin
          if (j_r == t_yl_r) begin
            i_r     <= CW'(1);
            state_r <= S_ROW_I;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_ROW_I: begin
          if (i_r > r_xl) begin
            j_r <= '0;
            if (!bwd_r) begin
              bwd_r   <= 1'b1;
              state_r <= S_INIT;
            end else begin
              found_r <= 1'b0;
              state_r <= S_SA;
            end
          end else begin
            j_r     <= CW'(1);
            diag_r  <= '0;
            left_r  <= '0;
            state_r <= S_CA;
          end
        end
        S_CA: begin
          // x symbol arrives once per row, right after it was issued
          if (j_r == CW'(1)) a_r <= x_rdata;
          state_r <= S_CB;
        end
        S_CB: begin
          diag_r <= above;
          left_r <= cell_new;
          if (j_r == t_yl_r) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_ROW_I;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_CA;
          end
        end
        S_SA: state_r <= S_SB;
        S_SB: begin
          // strict compare keeps the smallest split point
          if (!found_r || sum > best_r) begin
            best_r  <= sum;
            k_r     <= j_r;
            found_r <= 1'b1;
          end
          if (j_r == t_yl_r) begin
            state_r <= S_PUSH;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_SA;
          end
        end
        S_PUSH: begin
          // right half below left half so the left half pops first
          if (32'(sp_r) < STACK_DEPTH) begin
            stack_r[SIW'(sp_r)] <= right_task;
          end
          if (32'(sp_r) + 1 < STACK_DEPTH) begin
            stack_r[SIW'(sp_r + 1'b1)] <= left_task;
            sp_r <= sp_r + SPW'(2);
          end else if (32'(sp_r) < STACK_DEPTH) begin
            sp_r <= sp_r + 1'b1;
          end
          state_r <= S_POP;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
